// ----- sv/trsn_pkg.sv -----
// Shared types, constants and codes of the tree ring scan node.
package trsn_pkg;

   // Defaults of the top-level parameters.
   localparam int MAX_CHILDREN_DEF = 64;
   localparam int TOKEN_BITS_DEF   = 64;

   // Fixed field widths of the channels.
   localparam int SLOT_W     = 6;
   localparam int COUNT_W    = 32;
   localparam int TOKEN_W    = 64;
   localparam int CFG_W      = 7;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_APP_CHILDREN   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_CHILDREN = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IS_ROOT        = 8'd2;

   // Opcodes of input beats and directions of result beats.
   localparam logic OP_UP    = 1'b0;
   localparam logic OP_DOWN  = 1'b1;
   localparam logic DIR_UP   = 1'b0;
   localparam logic DIR_DOWN = 1'b1;

   typedef struct packed {
      logic                opcode;
      logic [SLOT_W-1:0]   child_slot;
      logic [COUNT_W-1:0]  item_count;
      logic [TOKEN_W-1:0]  left_token;
      logic                left_valid;
      logic [TOKEN_W-1:0]  right_token;
      logic                right_valid;
   } req_type;

   typedef struct packed {
      logic                direction;
      logic [SLOT_W-1:0]   target_slot;
      logic [COUNT_W-1:0]  out_count;
      logic [TOKEN_W-1:0]  out_left;
      logic                out_left_valid;
      logic [TOKEN_W-1:0]  out_right;
      logic                out_right_valid;
      logic                last;
   } rsp_type;

   // Effective child counts after clamping, and the root flag.
   typedef struct packed {
      logic [CFG_W-1:0] eff_total;
      logic [CFG_W-1:0] eff_app;
      logic             is_root;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_SUM_OUT,
      ST_BACK,
      ST_PRE,
      ST_EMIT_TREE,
      ST_EMIT_APP,
      ST_CLEAR
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr_en;          // store an up report
      logic rd_en;          // read the store at the controller's address
      logic sum_clear;      // restart the summary accumulators
      logic down_from_req;  // load down parameters from the input beat
      logic down_from_sum;  // load down parameters from the summary (root)
      logic fwd_init;       // restart the forward rank and left token
      logic cons_sum;       // fold the read entry into the summary
      logic cons_back;      // backward step: record the right neighbour
      logic cons_fwd;       // forward step: advance rank and left token
      logic cons_emit;      // send the read entry's assignment
      logic cons_first;     // the read entry is slot 0
      logic cons_final;     // the read entry ends the pass
      logic cons_last;      // the assignment is the last of the down item
      logic up_out;         // send the summary to the parent
      logic store_clear;    // drop all stored reports
   } cmd_type;

   typedef struct packed {
      logic out_free;       // the result register can take a beat now
   } status_type;

endpackage

// ----- sv/trsn_csr.sv -----
// Configuration registers of the tree ring scan node and their clamping.
module trsn_csr #(
   parameter int MAX_CHILDREN = trsn_pkg::MAX_CHILDREN_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [trsn_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [trsn_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output trsn_pkg::cfg_type                    cfg
);
   import trsn_pkg::*;

   localparam logic [CFG_W-1:0] MAX_C = CFG_W'(MAX_CHILDREN);

   logic [CFG_W-1:0] app_ff, app_in;
   logic [CFG_W-1:0] total_ff, total_in;
   logic             root_ff, root_in;
   logic [CFG_W-1:0] eff_total;

   assign csr_ready = 1'b1;

   always_comb begin
      app_in   = app_ff;
      total_in = total_ff;
      root_in  = root_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_APP_CHILDREN:   app_in   = csr_wdata[CFG_W-1:0];
            CSR_TOTAL_CHILDREN: total_in = csr_wdata[CFG_W-1:0];
            CSR_IS_ROOT:        root_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         app_ff   <= CFG_W'(1);
         total_ff <= CFG_W'(1);
         root_ff  <= 1'b1;
      end else begin
         app_ff   <= app_in;
         total_ff <= total_in;
         root_ff  <= root_in;
      end
   end

   assign eff_total     = (total_ff > MAX_C) ? MAX_C : total_ff;
   assign cfg.eff_total = eff_total;
   assign cfg.eff_app   = (app_ff > eff_total) ? eff_total : app_ff;
   assign cfg.is_root   = root_ff;

endmodule

// ----- sv/trsn_ctrl.sv -----
// Controller of the tree ring scan node: pass sequencing and read pipeline.
module trsn_ctrl #(
   parameter int MAX_CHILDREN = trsn_pkg::MAX_CHILDREN_DEF,
   localparam int IDX_W = $clog2(MAX_CHILDREN)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  trsn_pkg::cfg_type               cfg,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_opcode,
   input  logic [trsn_pkg::SLOT_W-1:0]     req_slot,
   input  trsn_pkg::status_type            status,
   output trsn_pkg::cmd_type               cmd,
   output logic [IDX_W-1:0]                rd_addr
);
   import trsn_pkg::*;

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] addr_ff, addr_in;
   logic [CFG_W-1:0] rem_ff, rem_in;
   logic [CFG_W-1:0] reports_ff, reports_in;
   logic             pend_ff, pend_in;
   logic             pend_first_ff, pend_first_in;
   logic             pend_final_ff, pend_final_in;
   logic             pend_last_ff, pend_last_in;

   logic             accept;
   logic             up_store;
   logic [CFG_W-1:0] rep_next;
   logic             sum_start;
   logic             emit_state;
   logic             cons;
   logic             rd_en;
   logic             done;
   logic             last_issue;
   logic             entering;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign up_store   = accept && (req_opcode == OP_UP) && (CFG_W'(req_slot) < cfg.eff_total);
   assign rep_next   = reports_ff + CFG_W'(1);
   assign sum_start  = up_store && (rep_next == cfg.eff_total);
   assign emit_state = (state_ff == ST_EMIT_TREE) || (state_ff == ST_EMIT_APP);

   // A read result waits in the read registers until it is taken; emissions also need
   // room in the result register.
   assign cons       = pend_ff && (!emit_state || status.out_free);
   assign rd_en      = (rem_ff != '0) && (!pend_ff || cons);
   assign done       = (rem_ff == '0) && (!pend_ff || cons);
   assign last_issue = (rem_ff == CFG_W'(1)) &&
                       ((state_ff == ST_EMIT_APP) ||
                        ((state_ff == ST_EMIT_TREE) && (cfg.eff_app == '0)));
   assign entering   = (state_in != state_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_DOWN)) begin
               state_in = ST_BACK;
            end else if (sum_start) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (done) state_in = ST_SUM_OUT;
         end
         ST_SUM_OUT: begin
            if (cfg.is_root) begin
               state_in = ST_BACK;
            end else if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_BACK: begin
            if (done) state_in = ST_PRE;
         end
         ST_PRE: begin
            if (done) state_in = ST_EMIT_TREE;
         end
         ST_EMIT_TREE: begin
            if (done) state_in = ST_EMIT_APP;
         end
         ST_EMIT_APP: begin
            if (done) state_in = ST_CLEAR;
         end
         ST_CLEAR: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      addr_in = addr_ff;
      rem_in  = rem_ff;
      if (rd_en) begin
         rem_in  = rem_ff - CFG_W'(1);
         addr_in = (state_ff == ST_BACK) ? addr_ff - CFG_W'(1) : addr_ff + CFG_W'(1);
      end
      if (entering) begin
         unique case (state_in)
            ST_SUM: begin
               addr_in = '0;
               rem_in  = cfg.eff_total;
            end
            ST_BACK: begin
               addr_in = cfg.eff_total - CFG_W'(1);
               rem_in  = cfg.eff_total;
            end
            ST_PRE, ST_EMIT_APP: begin
               addr_in = '0;
               rem_in  = cfg.eff_app;
            end
            ST_EMIT_TREE: begin
               addr_in = cfg.eff_app;
               rem_in  = cfg.eff_total - cfg.eff_app;
            end
            default: begin
               addr_in = '0;
               rem_in  = '0;
            end
         endcase
      end
   end

   always_comb begin
      pend_in       = rd_en ? 1'b1 : (cons ? 1'b0 : pend_ff);
      pend_first_in = rd_en ? (addr_ff == '0) : pend_first_ff;
      pend_final_in = rd_en ? (rem_ff == CFG_W'(1)) : pend_final_ff;
      pend_last_in  = rd_en ? last_issue : pend_last_ff;
      reports_in    = reports_ff;
      if (state_ff == ST_CLEAR) begin
         reports_in = '0;
      end else if (up_store) begin
         reports_in = rep_next;
      end
   end

   always_comb begin
      cmd               = '0;
      cmd.wr_en         = up_store;
      cmd.rd_en         = rd_en;
      cmd.sum_clear     = (state_ff == ST_IDLE);
      cmd.down_from_req = accept && (req_opcode == OP_DOWN);
      cmd.down_from_sum = (state_ff == ST_SUM_OUT) && cfg.is_root;
      cmd.fwd_init      = entering && ((state_in == ST_PRE) || (state_in == ST_EMIT_APP));
      cmd.cons_sum      = cons && (state_ff == ST_SUM);
      cmd.cons_back     = cons && (state_ff == ST_BACK);
      cmd.cons_fwd      = cons && ((state_ff == ST_PRE) || emit_state);
      cmd.cons_emit     = cons && emit_state;
      cmd.cons_first    = pend_first_ff;
      cmd.cons_final    = pend_final_ff;
      cmd.cons_last     = pend_last_ff;
      cmd.up_out        = (state_ff == ST_SUM_OUT) && !cfg.is_root && status.out_free;
      cmd.store_clear   = (state_ff == ST_CLEAR);
   end

   assign rd_addr = addr_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         addr_ff       <= '0;
         rem_ff        <= '0;
         reports_ff    <= '0;
         pend_ff       <= 1'b0;
         pend_first_ff <= 1'b0;
         pend_final_ff <= 1'b0;
         pend_last_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         rem_ff        <= rem_in;
         reports_ff    <= reports_in;
         pend_ff       <= pend_in;
         pend_first_ff <= pend_first_in;
         pend_final_ff <= pend_final_in;
         pend_last_ff  <= pend_last_in;
      end
   end

endmodule

// ----- sv/trsn_dp.sv -----
// Datapath of the tree ring scan node: report store, scan accumulators, result register.
module trsn_dp #(
   parameter int MAX_CHILDREN = trsn_pkg::MAX_CHILDREN_DEF,
   parameter int TOKEN_BITS   = trsn_pkg::TOKEN_BITS_DEF,
   localparam int IDX_W = $clog2(MAX_CHILDREN)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  trsn_pkg::req_type       req_data,
   input  trsn_pkg::cmd_type       cmd,
   input  logic [IDX_W-1:0]        rd_addr,
   output trsn_pkg::status_type    status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output trsn_pkg::rsp_type       rsp_data
);
   import trsn_pkg::*;

   localparam int WORD_W = COUNT_W + 2 * TOKEN_BITS;

   // Store word: count, left token, right token.
   logic [WORD_W-1:0]     slot_mem [MAX_CHILDREN];
   // Right neighbour of each slot from the backward pass: present flag and token.
   logic [TOKEN_BITS:0]   ar_mem   [MAX_CHILDREN];

   logic [WORD_W-1:0]     rd_word_ff;
   logic [TOKEN_BITS:0]   ar_rd_ff;
   logic [IDX_W-1:0]      rd_addr_ff;
   logic                  rd_cv_ff, rd_lp_ff, rd_rp_ff;

   logic [MAX_CHILDREN-1:0] cv_ff, cv_in;
   logic [MAX_CHILDREN-1:0] lp_ff, lp_in;
   logic [MAX_CHILDREN-1:0] rp_ff, rp_in;

   logic [COUNT_W-1:0]    sum_ff, sum_in;
   logic [TOKEN_BITS-1:0] sl_ff, sl_in, sr_ff, sr_in;
   logic                  slv_ff, slv_in, srv_ff, srv_in;
   logic [COUNT_W-1:0]    start_ff, start_in;
   logic [TOKEN_BITS-1:0] init_lt_ff, init_lt_in;
   logic                  init_lv_ff, init_lv_in;
   logic [TOKEN_BITS-1:0] bt_ff, bt_in;
   logic                  bv_ff, bv_in;
   logic [COUNT_W-1:0]    rank_ff, rank_in;
   logic [TOKEN_BITS-1:0] fl_ff, fl_in;
   logic                  flv_ff, flv_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0]      wr_idx;
   logic [COUNT_W-1:0]    rd_count;
   logic [TOKEN_BITS-1:0] rd_left, rd_right;
   logic                  out_free;

   assign wr_idx   = req_data.child_slot[IDX_W-1:0];
   assign rd_count = rd_cv_ff ? rd_word_ff[WORD_W-1 -: COUNT_W] : '0;
   assign rd_left  = rd_word_ff[2*TOKEN_BITS-1 -: TOKEN_BITS];
   assign rd_right = rd_word_ff[TOKEN_BITS-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign status.out_free = out_free;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slot_mem[wr_idx] <= {req_data.item_count,
                              req_data.left_token[TOKEN_BITS-1:0],
                              req_data.right_token[TOKEN_BITS-1:0]};
      end
      if (cmd.rd_en) begin
         rd_word_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cons_back) begin
         ar_mem[rd_addr_ff] <= {bv_ff, bt_ff};
      end
      if (cmd.rd_en) begin
         ar_rd_ff <= ar_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_addr_ff <= rd_addr;
         rd_cv_ff   <= cv_ff[rd_addr];
         rd_lp_ff   <= lp_ff[rd_addr];
         rd_rp_ff   <= rp_ff[rd_addr];
      end
   end

   always_comb begin
      cv_in = cv_ff;
      lp_in = lp_ff;
      rp_in = rp_ff;
      if (cmd.store_clear) begin
         cv_in = '0;
         lp_in = '0;
         rp_in = '0;
      end else if (cmd.wr_en) begin
         cv_in[wr_idx] = 1'b1;
         lp_in[wr_idx] = req_data.left_valid;
         rp_in[wr_idx] = req_data.right_valid;
      end
   end

   // Summary pass: count total, left token of slot 0, right token of the last slot.
   always_comb begin
      sum_in = sum_ff;
      sl_in  = sl_ff;
      slv_in = slv_ff;
      sr_in  = sr_ff;
      srv_in = srv_ff;
      if (cmd.sum_clear) begin
         sum_in = '0;
      end else if (cmd.cons_sum) begin
         sum_in = sum_ff + rd_count;
         if (cmd.cons_first) begin
            sl_in  = rd_left;
            slv_in = rd_lp_ff;
         end
         if (cmd.cons_final) begin
            sr_in  = rd_right;
            srv_in = rd_rp_ff;
         end
      end
   end

   // Down parameters and the backward (right neighbour) accumulator.
   always_comb begin
      start_in   = start_ff;
      init_lt_in = init_lt_ff;
      init_lv_in = init_lv_ff;
      bt_in      = bt_ff;
      bv_in      = bv_ff;
      priority if (cmd.down_from_req) begin
         start_in   = req_data.item_count;
         init_lt_in = req_data.left_token[TOKEN_BITS-1:0];
         init_lv_in = req_data.left_valid;
         bt_in      = req_data.right_token[TOKEN_BITS-1:0];
         bv_in      = req_data.right_valid;
      end else if (cmd.down_from_sum) begin
         start_in   = '0;
         init_lt_in = sr_ff;
         init_lv_in = srv_ff;
         bt_in      = sl_ff;
         bv_in      = slv_ff;
      end else if (cmd.cons_back && rd_lp_ff) begin
         bt_in = rd_left;
         bv_in = 1'b1;
      end
   end

   // Forward accumulator: exclusive rank and left neighbour.
   always_comb begin
      rank_in = rank_ff;
      fl_in   = fl_ff;
      flv_in  = flv_ff;
      if (cmd.fwd_init) begin
         rank_in = start_ff;
         fl_in   = init_lt_ff;
         flv_in  = init_lv_ff;
      end else if (cmd.cons_fwd) begin
         rank_in = rank_ff + rd_count;
         if (rd_rp_ff) begin
            fl_in  = rd_right;
            flv_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (cmd.cons_emit) begin
         rsp_in.direction       = DIR_DOWN;
         rsp_in.target_slot     = SLOT_W'(rd_addr_ff);
         rsp_in.out_count       = rank_ff;
         rsp_in.out_left        = flv_ff ? TOKEN_W'(fl_ff) : '0;
         rsp_in.out_left_valid  = flv_ff;
         rsp_in.out_right       = ar_rd_ff[TOKEN_BITS] ?
                                  TOKEN_W'(ar_rd_ff[TOKEN_BITS-1:0]) : '0;
         rsp_in.out_right_valid = ar_rd_ff[TOKEN_BITS];
         rsp_in.last            = cmd.cons_last;
         rsp_valid_in           = 1'b1;
      end else if (cmd.up_out) begin
         rsp_in.direction       = DIR_UP;
         rsp_in.target_slot     = '0;
         rsp_in.out_count       = sum_ff;
         rsp_in.out_left        = slv_ff ? TOKEN_W'(sl_ff) : '0;
         rsp_in.out_left_valid  = slv_ff;
         rsp_in.out_right       = srv_ff ? TOKEN_W'(sr_ff) : '0;
         rsp_in.out_right_valid = srv_ff;
         rsp_in.last            = 1'b1;
         rsp_valid_in           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff     <= sum_in;
      sl_ff      <= sl_in;
      slv_ff     <= slv_in;
      sr_ff      <= sr_in;
      srv_ff     <= srv_in;
      start_ff   <= start_in;
      init_lt_ff <= init_lt_in;
      init_lv_ff <= init_lv_in;
      bt_ff      <= bt_in;
      bv_ff      <= bv_in;
      rank_ff    <= rank_in;
      fl_ff      <= fl_in;
      flv_ff     <= flv_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff        <= '0;
         lp_ff        <= '0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cv_ff        <= cv_in;
         lp_ff        <= lp_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sv/tree_ring_scan_node_core.sv -----
// Top level of the tree ring scan node: configuration, controller and datapath.
//
// The node collects up reports from its children on the req_ channel and
// answers on the rsp_ channel, one result per beat with a last flag on the
// final beat of each input beat. An up report for a slot inside the child
// count is stored as it is taken, and unless it completes the set the node
// stays ready. The report that completes the set starts a summary pass over
// the store, one slot per cycle; a non-root node then sends the summary up.
// A root node instead turns the summary straight into a down phase with the
// two ends swapped. A down beat runs three passes over the store at one slot
// per cycle while the receiver does not stall: a backward pass for the right
// neighbours, a forward pass over the application slots, then one result
// beat per child, tree children first. The store is cleared in a clear state
// at the end of the down phase. Items are taken one at a time; req_ready is
// high only while the node is idle. A stalled receiver holds the result
// register and the emission pass simply waits. Reset is synchronous and
// empties the store; the registers return to one child, one application
// child and root. The csr_ port takes a write every cycle.
module tree_ring_scan_node_core #(
   parameter int MAX_CHILDREN = trsn_pkg::MAX_CHILDREN_DEF,
   parameter int TOKEN_BITS   = trsn_pkg::TOKEN_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  trsn_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output trsn_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [trsn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [trsn_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import trsn_pkg::*;

   localparam int IDX_W = $clog2(MAX_CHILDREN);

   cfg_type          cfg;
   cmd_type          cmd;
   status_type       status;
   logic [IDX_W-1:0] rd_addr;

   // Register file; the effective counts are clamped to the store depth here.
   trsn_csr #(
      .MAX_CHILDREN (MAX_CHILDREN)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The controller owns the handshake on the input side, the report counter
   // and the pass sequencing.
   trsn_ctrl #(
      .MAX_CHILDREN (MAX_CHILDREN)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_data.opcode),
      .req_slot   (req_data.child_slot),
      .status     (status),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   // The datapath holds the store, the accumulators and the result register.
   trsn_dp #(
      .MAX_CHILDREN (MAX_CHILDREN),
      .TOKEN_BITS   (TOKEN_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- bench/tree_ring_scan_node_core_test.sv -----
// Self-checking testbench of the tree ring scan node core with its own scan predictor.
module tree_ring_scan_node_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import trsn_pkg::*;

   // The bench runs the block at its default sizes: 64 child slots and full 64-bit tokens,
   // so token masking never removes a bit.
   localparam int MAX_SLOTS = MAX_CHILDREN_DEF;

   // After a beat that causes no result the node may still be walking its store, and a
   // down beat over 64 slots takes two passes plus the emissions. Waiting this long before
   // touching the registers leaves it idle whatever it was doing.
   localparam int SETTLE_CYCLES = 250;

   // Random beats that reach the node's state (ignored up reports excluded).
   localparam int RANDOM_TARGET = 90;

   // Hard stop. The slowest honest run is about a hundred and fifty beats, each down beat
   // giving up to 64 results that may each sit out a receiver stall; this is several
   // times that.
   localparam int CYCLE_LIMIT = 1000000;

   // Only the first mismatches are printed; the rest are just counted.
   localparam int PRINT_LIMIT = 40;

   typedef struct {
      req_type beat;
      bit      hold;   // wait for every awaited result before offering this beat
   } queued_beat_type;

   // ---------------------------------------------------------------------------------------
   // Clock, reset and the ports of the block. Every input has a known value from time zero.
   // ---------------------------------------------------------------------------------------
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   always #10 clock = ~clock;

   tree_ring_scan_node_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ---------------------------------------------------------------------------------------
   // Scan predictor state: the registers as the node sees them and the child report store.
   // ---------------------------------------------------------------------------------------
   logic [CFG_W-1:0]   node_app;
   logic [CFG_W-1:0]   node_total;
   logic               node_root;
   logic [COUNT_W-1:0] slot_count_q  [MAX_SLOTS];
   logic [TOKEN_W-1:0] slot_left_tok [MAX_SLOTS];
   logic               slot_left_ok  [MAX_SLOTS];
   logic [TOKEN_W-1:0] slot_right_tok[MAX_SLOTS];
   logic               slot_right_ok [MAX_SLOTS];
   logic [CFG_W-1:0]   reports_seen;

   // Result beats the node owes, oldest first, and the beats still to be offered.
   rsp_type          awaited_results[$];
   queued_beat_type  pending_beats[$];

   // Bookkeeping.
   int  mismatch_count  = 0;
   int  results_checked = 0;
   int  beats_taken     = 0;
   int  downs_taken     = 0;
   int  settings_used   = 0;
   int  useful_beats    = 0;
   int  cycle_count     = 0;
   bit  req_fire        = 1'b0;

   // What the stimulus generator believes the node is configured as.
   int  gen_total = 1;
   bit  gen_root  = 1'b1;

   // Sender burst state and receiver stall pattern.
   int          burst_left    = 1;
   int          gap_left      = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   int          stall_phase   = 0;
   int          stall_age     = 0;

   // ---------------------------------------------------------------------------------------
   // Predictor.
   // ---------------------------------------------------------------------------------------

   // The child count is clamped to the slot store, and the application count to that.
   function automatic int live_total();
      return (int'(node_total) > MAX_SLOTS) ? MAX_SLOTS : int'(node_total);
   endfunction

   function automatic int live_app();
      int t;
      t = live_total();
      return (int'(node_app) > t) ? t : int'(node_app);
   endfunction

   function automatic void clear_store();
      for (int s = 0; s < MAX_SLOTS; s++) begin
         slot_count_q[s]  = '0;
         slot_left_ok[s]  = 1'b0;
         slot_right_ok[s] = 1'b0;
      end
      reports_seen = '0;
   endfunction

   function automatic void reset_model();
      clear_store();
      for (int s = 0; s < MAX_SLOTS; s++) begin
         slot_left_tok[s]  = '0;
         slot_right_tok[s] = '0;
      end
      node_app   = 7'd1;
      node_total = 7'd1;
      node_root  = 1'b1;
   endfunction

   // Absent tokens travel as zero.
   function automatic rsp_type shape_result(logic dir, int slot, logic [COUNT_W-1:0] cnt,
                                            logic [TOKEN_W-1:0] l, logic lv,
                                            logic [TOKEN_W-1:0] r, logic rv, logic fin);
      rsp_type res;
      res.direction       = dir;
      res.target_slot     = slot[SLOT_W-1:0];
      res.out_count       = cnt;
      res.out_left        = lv ? l : '0;
      res.out_left_valid  = lv;
      res.out_right       = rv ? r : '0;
      res.out_right_valid = rv;
      res.last            = fin;
      return res;
   endfunction

   // Down phase: exclusive prefix ranks, left neighbours from a forward walk and right
   // neighbours from a backward walk, skipping absent tokens. Tree children are answered
   // before application children, then the store empties.
   function automatic void assign_ranks(logic [COUNT_W-1:0] start,
                                        logic [TOKEN_W-1:0] lt, logic lv,
                                        logic [TOKEN_W-1:0] rt, logic rv);
      logic [COUNT_W-1:0] rank       [MAX_SLOTS];
      logic [TOKEN_W-1:0] left_nb    [MAX_SLOTS];
      logic               left_nb_ok [MAX_SLOTS];
      logic [TOKEN_W-1:0] right_nb   [MAX_SLOTS];
      logic               right_nb_ok[MAX_SLOTS];
      int                 total, app, k, s;
      total = live_total();
      app   = live_app();
      for (s = 0; s < total; s++) begin
         rank[s]       = start;
         start         = start + slot_count_q[s];
         left_nb[s]    = lt;
         left_nb_ok[s] = lv;
         if (slot_right_ok[s]) begin
            lt = slot_right_tok[s];
            lv = 1'b1;
         end
      end
      for (s = total - 1; s >= 0; s--) begin
         right_nb[s]    = rt;
         right_nb_ok[s] = rv;
         if (slot_left_ok[s]) begin
            rt = slot_left_tok[s];
            rv = 1'b1;
         end
      end
      for (k = 0; k < total; k++) begin
         s = (k < total - app) ? app + k : k - (total - app);
         awaited_results.push_back(shape_result(DIR_DOWN, s, rank[s], left_nb[s], left_nb_ok[s],
                                                right_nb[s], right_nb_ok[s], k + 1 == total));
      end
      clear_store();
   endfunction

   // One accepted input beat: update the store and queue whatever results it causes.
   function automatic void predict_scan_node(req_type beat);
      int                 total, s;
      logic [COUNT_W-1:0] sum;
      total = live_total();
      if (beat.opcode == OP_DOWN) begin
         assign_ranks(beat.item_count, beat.left_token, beat.left_valid,
                      beat.right_token, beat.right_valid);
         return;
      end
      // Reports from slots outside the child count leave no trace at all.
      if (int'(beat.child_slot) >= total)
         return;
      s = beat.child_slot;
      slot_count_q[s]   = beat.item_count;
      slot_left_tok[s]  = beat.left_token;
      slot_left_ok[s]   = beat.left_valid;
      slot_right_tok[s] = beat.right_token;
      slot_right_ok[s]  = beat.right_valid;
      // A repeated report still counts, and the tally wraps at seven bits.
      reports_seen = reports_seen + 7'd1;
      if (int'(reports_seen) != total)
         return;
      sum = '0;
      for (s = 0; s < total; s++)
         sum = sum + slot_count_q[s];
      if (node_root) begin
         // The root closes the ring: the rightmost token wraps round to the left end.
         assign_ranks('0, slot_right_tok[total-1], slot_right_ok[total-1],
                      slot_left_tok[0], slot_left_ok[0]);
      end else begin
         awaited_results.push_back(shape_result(DIR_UP, 0, sum, slot_left_tok[0], slot_left_ok[0],
                                                slot_right_tok[total-1], slot_right_ok[total-1],
                                                1'b1));
      end
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_APP_CHILDREN:   node_app   = value[CFG_W-1:0];
         CSR_TOTAL_CHILDREN: node_total = value[CFG_W-1:0];
         CSR_IS_ROOT:        node_root  = value[0];
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Checking.
   // ---------------------------------------------------------------------------------------
   function automatic void report_mismatch(string what, logic [63:0] seen, logic [63:0] wanted);
      if (mismatch_count < PRINT_LIMIT)
         $display("[%0t] mismatch on result %0d: %s is %h, expected %h",
                  $realtime, results_checked, what, seen, wanted);
      mismatch_count++;
   endfunction

   function automatic void compare_field(string what, logic [63:0] seen, logic [63:0] wanted);
      if (seen !== wanted)
         report_mismatch(what, seen, wanted);
   endfunction

   function automatic void check_result(rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch("unsolicited beat, out_count", 64'(got.out_count), '0);
         return;
      end
      want = awaited_results.pop_front();
      results_checked++;
      compare_field("direction",       64'(got.direction),       64'(want.direction));
      compare_field("target_slot",     64'(got.target_slot),     64'(want.target_slot));
      compare_field("out_count",       64'(got.out_count),       64'(want.out_count));
      compare_field("out_left",        got.out_left,             want.out_left);
      compare_field("out_left_valid",  64'(got.out_left_valid),  64'(want.out_left_valid));
      compare_field("out_right",       got.out_right,            want.out_right);
      compare_field("out_right_valid", 64'(got.out_right_valid), 64'(want.out_right_valid));
      compare_field("last",            64'(got.last),            64'(want.last));
   endfunction

   // ---------------------------------------------------------------------------------------
   // Monitor. Everything is sampled at the rising edge, before the block's own registers
   // move. A result is checked before a new beat is predicted, as the new beat cannot have
   // caused it.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_fire = 1'b0;
         reset_model();
      end else begin
         req_fire = req_valid && req_ready;
         if (rsp_valid && rsp_ready)
            check_result(rsp_data);
         if (csr_valid && csr_ready)
            apply_register(csr_index, csr_wdata);
         if (req_fire) begin
            beats_taken++;
            if (req_data.opcode == OP_DOWN)
               downs_taken++;
            predict_scan_node(req_data);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at %0d cycles with %0d beats queued and %0d results owed.",
                  cycle_count, pending_beats.size(), awaited_results.size());
         $display("tree_ring_scan_node_core verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Driver. Beats leave the queue in bursts of random length with random gaps between them;
   // a beat marked hold is not offered while results are still owed. Once offered, a beat
   // stays on the port unchanged until it is taken.
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() != 0 &&
                      !(pending_beats[0].hold && awaited_results.size() != 0)) begin
            req_data  <= pending_beats[0].beat;
            req_valid <= 1'b1;
            void'(pending_beats.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               // Now and then a long burst gives a stretch with no idling at all.
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 8);
               gap_left   = $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. Ready follows a rotating 16-bit pattern that is replaced every so often:
   // always ready, a random pattern, one cycle in sixteen, or every other cycle. The pattern
   // always keeps at least one ready bit.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         stall_age++;
         if (stall_age % 150 == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pattern = 16'hFFFF;
               1:       stall_pattern = 16'($urandom) | 16'h0001;
               2:       stall_pattern = 16'h0001;
               default: stall_pattern = 16'hAAAA;
            endcase
         end
         rsp_ready   <= stall_pattern[stall_phase];
         stall_phase = (stall_phase + 1) % 16;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------------------
   function automatic req_type make_beat(logic op, int slot, logic [COUNT_W-1:0] cnt,
                                         logic [TOKEN_W-1:0] lt, logic lv,
                                         logic [TOKEN_W-1:0] rt, logic rv);
      req_type b;
      b.opcode      = op;
      b.child_slot  = slot[SLOT_W-1:0];
      b.item_count  = cnt;
      b.left_token  = lt;
      b.left_valid  = lv;
      b.right_token = rt;
      b.right_valid = rv;
      return b;
   endfunction

   // Tokens and counts lean towards their extremes now and then.
   function automatic logic [TOKEN_W-1:0] rand_token();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [COUNT_W-1:0] rand_count();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(0, 20);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic rand_flag();
      return $urandom_range(0, 3) != 0;
   endfunction

   function automatic req_type random_up(int slot);
      return make_beat(OP_UP, slot, rand_count(), rand_token(), rand_flag(),
                       rand_token(), rand_flag());
   endfunction

   function automatic req_type random_down();
      return make_beat(OP_DOWN, $urandom_range(0, MAX_SLOTS - 1), rand_count(), rand_token(),
                       rand_flag(), rand_token(), rand_flag());
   endfunction

   function automatic void push_beat(req_type b, bit hold);
      queued_beat_type e;
      e.beat = b;
      e.hold = hold || ($urandom_range(0, 29) == 0);
      pending_beats.push_back(e);
      if (b.opcode == OP_DOWN || int'(b.child_slot) < gen_total)
         useful_beats++;
   endfunction

   // One scan round: most rounds are a full set of reports in shuffled order followed by
   // the parent's down beat. Some get stray reports from slots outside the child count or
   // a repeated report, some are cut short before the down beat, and some are plain noise.
   function automatic void queue_round(bit whole);
      int order[MAX_SLOTS];
      int k, j, tmp, cut;
      if (gen_total == 0 || (!whole && $urandom_range(0, 4) == 0)) begin
         repeat ($urandom_range(1, 4))
            push_beat($urandom_range(0, 1) ? random_down() : random_up($urandom_range(0, 63)),
                      1'b0);
         return;
      end
      for (k = 0; k < gen_total; k++)
         order[k] = k;
      for (k = gen_total - 1; k > 0; k--) begin
         j        = $urandom_range(0, k);
         tmp      = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      cut = (!whole && $urandom_range(0, 7) == 0) ? $urandom_range(0, gen_total - 1) : gen_total;
      for (k = 0; k < cut; k++) begin
         if (gen_total < MAX_SLOTS && $urandom_range(0, 9) == 0)
            push_beat(random_up($urandom_range(gen_total, MAX_SLOTS - 1)), 1'b0);
         if (k > 0 && $urandom_range(0, 11) == 0)
            push_beat(random_up(order[$urandom_range(0, k - 1)]), 1'b0);
         push_beat(random_up(order[k]), 1'b0);
      end
      // A complete round at the root needs no down beat; one is sent now and then anyway.
      if (!gen_root || cut < gen_total || $urandom_range(0, 3) == 0)
         push_beat(random_down(), 1'b0);
   endfunction

   // Returns once every queued beat has been taken, every owed result has arrived and the
   // node has had time to finish any pass that produces nothing.
   task automatic wait_until_drained();
      while (pending_beats.size() != 0 || req_valid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Writes all three registers with random junk above the used bits, plus one write to an
   // index outside the map, which must leave the node alone.
   task automatic set_node_shape(logic [CFG_W-1:0] app, logic [CFG_W-1:0] total, logic root);
      wait_until_drained();
      write_reg(CSR_APP_CHILDREN,   ($urandom & ~32'h7F) | 32'(app));
      write_reg(CSR_TOTAL_CHILDREN, ($urandom & ~32'h7F) | 32'(total));
      write_reg(CSR_IS_ROOT,        ($urandom & ~32'h1) | 32'(root));
      write_reg(CSR_IDX_W'($urandom_range(CSR_IS_ROOT + 1, 255)), $urandom);
      gen_total = (int'(total) > MAX_SLOTS) ? MAX_SLOTS : int'(total);
      gen_root  = root;
      settings_used++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------------------------
   initial begin
      int base, phase, rounds, total_w, app_w;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settings_used = 1;

      // Reset shape: a single-child root. The one report closes the ring onto itself, a
      // report from the top slot is ignored, and a down beat on an empty store still answers.
      push_beat(make_beat(OP_UP, 0, '1, '1, 1'b1, '0, 1'b1), 1'b0);
      push_beat(make_beat(OP_UP, 63, '0, '1, 1'b1, '1, 1'b1), 1'b0);
      push_beat(make_beat(OP_DOWN, 63, '1, '0, 1'b0, '1, 1'b1), 1'b1);

      // Inner node with two application and two tree children. First a down beat that
      // arrives before all reports are in, then a full set whose summary goes up, then a
      // down beat whose start makes the ranks wrap.
      set_node_shape(7'd2, 7'd4, 1'b0);
      push_beat(make_beat(OP_UP, 3, 32'd5, 64'h0123_4567_89AB_CDEF, 1'b1, '1, 1'b0), 1'b0);
      push_beat(make_beat(OP_UP, 0, 32'd7, '1, 1'b0, 64'hFEDC_BA98_7654_3210, 1'b1), 1'b0);
      push_beat(make_beat(OP_UP, 1, '0, '0, 1'b0, '0, 1'b0), 1'b0);
      push_beat(make_beat(OP_DOWN, 0, 32'd100, 64'h1111_2222_3333_4444, 1'b1,
                          64'h5555_6666_7777_8888, 1'b1), 1'b0);
      push_beat(make_beat(OP_UP, 2, 32'd3, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, '0, 1'b1), 1'b0);
      push_beat(make_beat(OP_UP, 0, 32'd1, '0, 1'b1, 64'h5A5A_5A5A_5A5A_5A5A, 1'b1), 1'b0);
      push_beat(make_beat(OP_UP, 3, '1, '1, 1'b0, '1, 1'b1), 1'b0);
      push_beat(make_beat(OP_UP, 1, 32'd2, 64'h8000_0000_0000_0001, 1'b1, '1, 1'b0), 1'b0);
      push_beat(make_beat(OP_DOWN, 42, 32'hFFFF_FFF0, '0, 1'b0, '1, 1'b0), 1'b0);

      // Child count lowered below the reports already held: no summary can follow, and the
      // down beat works on the store as it stands.
      set_node_shape(7'd1, 7'd4, 1'b0);
      push_beat(random_up(0), 1'b0);
      push_beat(random_up(1), 1'b0);
      push_beat(random_up(2), 1'b0);
      set_node_shape(7'd1, 7'd2, 1'b0);
      push_beat(random_up(1), 1'b0);
      push_beat(random_down(), 1'b0);

      // Register values beyond the store clamp to 64 children, all of them application
      // children; a down beat then answers every slot.
      set_node_shape(7'd127, 7'd127, 1'b1);
      push_beat(make_beat(OP_DOWN, 17, 32'd9, '1, 1'b1, '0, 1'b1), 1'b0);

      // No children at all: every report is ignored and a down beat gives nothing.
      set_node_shape(7'd0, 7'd0, 1'b0);
      push_beat(make_beat(OP_UP, 0, 32'd4, '1, 1'b1, '1, 1'b1), 1'b0);
      push_beat(make_beat(OP_DOWN, 0, 32'd4, '1, 1'b1, '1, 1'b1), 1'b0);

      // A root with tree children only.
      set_node_shape(7'd0, 7'd3, 1'b1);
      push_beat(random_up(2), 1'b0);
      push_beat(random_up(0), 1'b0);
      push_beat(random_up(1), 1'b0);

      // Tally overrun: with one child and no root, the first report sends a summary and the
      // further reports push the tally past the child count, so no second summary follows.
      set_node_shape(CFG_W'($urandom_range(0, 2)), 7'd1, 1'b0);
      repeat (8) push_beat(random_up(0), 1'b0);
      push_beat(random_down(), 1'b0);

      // Random phases, mostly with small child counts and one at the full store size.
      phase = 0;
      base  = useful_beats;
      while (useful_beats - base < RANDOM_TARGET) begin
         total_w = (phase == 2) ? $urandom_range(64, 127) : $urandom_range(1, 6);
         app_w   = $urandom_range(0, (total_w + 2 > 127) ? 127 : total_w + 2);
         set_node_shape(app_w[CFG_W-1:0], total_w[CFG_W-1:0], 1'($urandom_range(0, 1)));
         if (phase == 0)
            push_beat(random_up(0), 1'b1);
         rounds = (phase == 2) ? 1 : $urandom_range(2, 4);
         repeat (rounds) queue_round(phase == 2);
         phase++;
      end

      wait_until_drained();
      $display("Run took %0d input beats (%0d down) under %0d register settings",
               beats_taken, downs_taken, settings_used);
      $display("and compared %0d results over clamped child counts, ring closure at the root, %s",
               results_checked, "stray and repeated reports and an overrun tally.");
      if (mismatch_count == 0) begin
         $display("tree_ring_scan_node_core verification clean");
      end else begin
         $display("tree_ring_scan_node_core verification failed");
      end
      $finish;
   end

endmodule
